@@ design/gf2inv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the GF(2^64) inverter.
// No dependencies.
package gf2inv_pkg;

	localparam int unsigned FIELD_W = 64;
	localparam int unsigned LEN_W   = 7;   // degree + 1, 0 means zero polynomial
	localparam int unsigned SHIFT_W = 6;
	localparam int unsigned STEP_W  = 8;

	localparam logic [FIELD_W-1:0] POLY_LOW  = 64'h1B;
	localparam logic [FIELD_W-1:0] POLY_ONE  = 64'h1;
	localparam logic [LEN_W-1:0]   MOD_LEN   = 7'd65;  // implicit x^64 term
	localparam logic [STEP_W-1:0]  STEP_CAP  = 8'd130;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic halt;
		logic out_free;
	} dp_status_t;

	// Polynomial degree plus one; zero for the zero polynomial.
	function automatic logic [LEN_W-1:0] poly_len(input logic [FIELD_W-1:0] v);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			if (v[i]) begin
				n = LEN_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

@@ design/gf2inv_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the inverter request and response.
// Depends on gf2inv_pkg.
interface gf2inv_req_if;
	import gf2inv_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] operand;

	modport source (output valid, output operand, input ready);
	modport sink   (input valid, input operand, output ready);
endinterface

interface gf2inv_rsp_if;
	import gf2inv_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] inverse;

	modport source (output valid, output inverse, input ready);
	modport sink   (input valid, input inverse, output ready);
endinterface

@@ design/gf2inv_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the inverter: load, Euclid iterations, result hand-off.
// Depends on gf2inv_pkg.
module gf2inv_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  gf2inv_pkg::dp_status_t status,
	output gf2inv_pkg::dp_cmd_t    cmd
);
	import gf2inv_pkg::*;

	state_t            state_q;
	state_t            state_nxt;
	logic [STEP_W-1:0] step_q;
	logic              at_cap;

	assign at_cap = (step_q == STEP_CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (status.halt || at_cap) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_RUN: begin
				cmd.step = !(status.halt || at_cap);
			end
			ST_DONE: begin
				cmd.emit = status.out_free;
			end
			default: cmd = '0;
		endcase
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_CAP)
		else $error("iteration count past cap");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.emit}))
		else $error("conflicting datapath commands");

	a_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> (state_q == ST_RUN || state_q == ST_DONE))
		else $error("run state left without finishing");

endmodule

@@ design/gf2inv_dpath.sv @@
`timescale 1ns / 1ps
// Euclid datapath: remainder/cofactor registers, swap, align, XOR, degree
// update, and the output register. Depends on gf2inv_pkg.
module gf2inv_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gf2inv_pkg::dp_cmd_t               cmd,
	output gf2inv_pkg::dp_status_t            status,
	input  logic [gf2inv_pkg::FIELD_W-1:0]    operand,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gf2inv_pkg::FIELD_W-1:0]    inverse
);
	import gf2inv_pkg::*;

	logic [FIELD_W-1:0] ra_q, rb_q, ca_q, cb_q;
	logic [LEN_W-1:0]   la_q, lb_q;
	logic               out_valid_q;
	logic [FIELD_W-1:0] inverse_q;

	logic               swap;
	logic [FIELD_W-1:0] ra_s, rb_s, ca_s, cb_s;
	logic [LEN_W-1:0]   la_s, lb_s;
	logic [LEN_W-1:0]   len_diff;
	logic [SHIFT_W-1:0] sh;
	logic [FIELD_W-1:0] ra_n, ca_n;
	logic [LEN_W-1:0]   la_n;

	always_comb begin
		swap     = (la_q < lb_q);
		ra_s     = swap ? rb_q : ra_q;
		rb_s     = swap ? ra_q : rb_q;
		ca_s     = swap ? cb_q : ca_q;
		cb_s     = swap ? ca_q : cb_q;
		la_s     = swap ? lb_q : la_q;
		lb_s     = swap ? la_q : lb_q;
		len_diff = la_s - lb_s;
		sh       = len_diff[SHIFT_W-1:0];
		if (lb_s != '0) begin
			ra_n = ra_s ^ (rb_s << sh);
			ca_n = ca_s ^ (cb_s << sh);
			la_n = poly_len(ra_n);
		end else begin
			ra_n = ra_s;
			ca_n = ca_s;
			la_n = la_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_q <= '0;
			rb_q <= '0;
			ca_q <= '0;
			cb_q <= '0;
			la_q <= '0;
			lb_q <= '0;
		end else if (cmd.load) begin
			ra_q <= POLY_LOW;
			rb_q <= operand;
			ca_q <= '0;
			cb_q <= POLY_ONE;
			la_q <= MOD_LEN;
			lb_q <= poly_len(operand);
		end else if (cmd.step) begin
			ra_q <= ra_n;
			rb_q <= rb_s;
			ca_q <= ca_n;
			cb_q <= cb_s;
			la_q <= la_n;
			lb_q <= lb_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			inverse_q <= (rb_q == POLY_ONE) ? cb_q : '0;
		end
	end

	assign status.halt     = (rb_q == '0) || (rb_q == POLY_ONE);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign inverse         = inverse_q;

	a_la_track: assert property (@(posedge clk) disable iff (!arst_n)
		(la_q == MOD_LEN) || (la_q == poly_len(ra_q)))
		else $error("first remainder degree out of step");

	a_lb_track: assert property (@(posedge clk) disable iff (!arst_n)
		lb_q == poly_len(rb_q))
		else $error("second remainder degree out of step");

endmodule

@@ design/gf2_64_inverter_core.sv @@
`timescale 1ns / 1ps
// GF(2^64) inverter top level, modulus x^64+x^4+x^3+x+1.
// Depends on gf2inv_pkg, gf2inv_if, gf2inv_ctrl, gf2inv_dpath.
//
//  channel  dir  payload           transfer when
//  req      in   operand[63:0]     req.valid && req.ready
//  rsp      out  inverse[63:0]     rsp.valid && rsp.ready
//
// One transfer in, then one Euclid iteration per cycle (swap, align, XOR,
// degree update) until the second remainder is 0 or 1; at most 130
// iterations (STEP_CAP), then the hand-off to the output register.
// req.ready is high only between items; a waiting result sits in the
// output register and does not block the next request.
// Reset clears all state but the output data; nothing is kept between items.
module gf2_64_inverter_core (
	input  logic              clk,
	input  logic              arst_n,
	gf2inv_req_if.sink        req,
	gf2inv_rsp_if.source      rsp
);
	import gf2inv_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	gf2inv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	gf2inv_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.operand   (req.operand),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.inverse   (rsp.inverse)
	);

endmodule
